// ===== sv/lre_pkg.sv =====
`timescale 1ns / 1ps

package lre_pkg;

	localparam int DATA_W = 64;
	localparam int OP_W   = 3;
	localparam int IDX_W  = 6;
	localparam int IDX_N  = 2 ** IDX_W;

	localparam logic [OP_W-1:0] OP_SET    = 3'd0;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_STEP   = 3'd2;
	localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [1:0] {
		ADDR_Y,
		ADDR_UP,
		ADDR_DN
	} addr_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_SET,
		WR_STEP,
		WR_FLUSH,
		WR_CMT,
		WR_CMT_END
	} wr_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_LIFE,
		RES_FLUSH
	} res_t;

	typedef struct packed {
		logic      ld_in;
		logic      clr_all;
		logic      cur_re;
		addr_sel_t cur_ra;
		logic      chg_re;
		logic      nxt_re;
		logic      cap_up;
		logic      cap_mid;
		wr_t       wr;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      out_ld;
		res_t      res_sel;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_last;
	} stat_t;

endpackage

// ===== sv/lre_datapath.sv =====
`timescale 1ns / 1ps

module lre_datapath import lre_pkg::*; #(
	parameter int BOARD_COLS = 64,
	parameter int BOARD_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [IDX_W-1:0]  col,
	input  logic [IDX_W-1:0]  row,
	input  logic              cell_value,
	input  logic              mark_changed,
	output logic [DATA_W-1:0] row_bits,
	output logic [DATA_W-1:0] change_bits
);

	localparam int RW = $clog2(BOARD_ROWS);
	localparam int CW = $clog2(BOARD_COLS);

	logic [RW-1:0] row_tbl [IDX_N];
	logic [CW-1:0] col_tbl [IDX_N];

	for (genvar i = 0; i < IDX_N; i++) begin : g_tbl
		localparam int RI = i % BOARD_ROWS;
		localparam int CI = i % BOARD_COLS;
		assign row_tbl[i] = RW'(RI);
		assign col_tbl[i] = CW'(CI);
	end

	logic [RW-1:0] y_q;
	logic [CW-1:0] x_q;
	logic          val_q;
	logic          mark_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			y_q    <= row_tbl[row];
			x_q    <= col_tbl[col];
			val_q  <= cell_value;
			mark_q <= mark_changed;
		end
	end

	logic [RW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.cnt_last = (cnt_q == RW'(BOARD_ROWS - 1));

	logic [RW-1:0] y_up;
	logic [RW-1:0] y_dn;
	logic [RW-1:0] cur_ra;

	assign y_up = (y_q == '0) ? RW'(BOARD_ROWS - 1) : y_q - 1'b1;
	assign y_dn = (y_q == RW'(BOARD_ROWS - 1)) ? '0 : y_q + 1'b1;

	always_comb begin
		unique case (cmd.cur_ra)
			ADDR_UP: cur_ra = y_up;
			ADDR_DN: cur_ra = y_dn;
			default: cur_ra = y_q;
		endcase
	end

	logic [BOARD_COLS-1:0] cur_mem [BOARD_ROWS];
	logic [BOARD_COLS-1:0] nxt_mem [BOARD_ROWS];
	logic [BOARD_COLS-1:0] chg_mem [BOARD_ROWS];

	logic [BOARD_ROWS-1:0] cur_vld_q;
	logic [BOARD_ROWS-1:0] nxt_vld_q;
	logic [BOARD_ROWS-1:0] chg_vld_q;

	logic [BOARD_COLS-1:0] cur_rd_q;
	logic [BOARD_COLS-1:0] nxt_rd_q;
	logic [BOARD_COLS-1:0] chg_rd_q;
	logic                  cur_v_q;
	logic                  nxt_v_q;
	logic                  chg_v_q;

	logic [BOARD_COLS-1:0] cur_eff;
	logic [BOARD_COLS-1:0] nxt_eff;
	logic [BOARD_COLS-1:0] chg_eff;

	assign cur_eff = cur_v_q ? cur_rd_q : '0;
	assign nxt_eff = nxt_v_q ? nxt_rd_q : '0;
	assign chg_eff = chg_v_q ? chg_rd_q : '1;

	logic [BOARD_COLS-1:0] up_q;
	logic [BOARD_COLS-1:0] mid_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_up) begin
			up_q <= cur_eff;
		end
		if (cmd.cap_mid) begin
			mid_q <= cur_eff;
		end
	end

	logic [BOARD_COLS-1:0] life;

	for (genvar x = 0; x < BOARD_COLS; x++) begin : g_cell
		localparam int XL = (x == 0) ? BOARD_COLS - 1 : x - 1;
		localparam int XR = (x == BOARD_COLS - 1) ? 0 : x + 1;
		logic [3:0] n;
		assign n = 4'(up_q[XL]) + 4'(up_q[x]) + 4'(up_q[XR])
			+ 4'(mid_q[XL]) + 4'(mid_q[XR])
			+ 4'(cur_eff[XL]) + 4'(cur_eff[x]) + 4'(cur_eff[XR]);
		assign life[x] = (n == BIRTH_COUNT) || (mid_q[x] && (n == SURVIVE_COUNT));
	end

	logic [BOARD_COLS-1:0] bit_sel;
	assign bit_sel = BOARD_COLS'(1) << x_q;

	logic                  cur_we;
	logic [RW-1:0]         cur_wa;
	logic [BOARD_COLS-1:0] cur_wd;
	logic                  nxt_we;
	logic                  chg_we;
	logic [BOARD_COLS-1:0] chg_wd;

	always_comb begin
		cur_we = 1'b0;
		cur_wa = y_q;
		cur_wd = (cur_eff & ~bit_sel) | (val_q ? bit_sel : '0);
		nxt_we = 1'b0;
		chg_we = 1'b0;
		chg_wd = chg_eff | bit_sel;
		unique case (cmd.wr)
			WR_SET: begin
				cur_we = 1'b1;
				chg_we = mark_q;
			end
			WR_STEP: begin
				nxt_we = 1'b1;
				chg_we = 1'b1;
				chg_wd = chg_eff | (life ^ mid_q);
			end
			WR_FLUSH: begin
				chg_we = 1'b1;
				chg_wd = '0;
			end
			WR_CMT: begin
				cur_we = !stat.cnt_zero;
				cur_wa = cnt_q - 1'b1;
				cur_wd = nxt_eff;
			end
			WR_CMT_END: begin
				cur_we = 1'b1;
				cur_wa = cnt_q;
				cur_wd = nxt_eff;
			end
			default: begin
				cur_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= '0;
			nxt_vld_q <= '0;
			chg_vld_q <= '0;
		end else if (cmd.clr_all) begin
			cur_vld_q <= '0;
			nxt_vld_q <= '0;
			chg_vld_q <= '0;
		end else begin
			if (cur_we) begin
				cur_vld_q[cur_wa] <= 1'b1;
			end
			if (nxt_we) begin
				nxt_vld_q[y_q] <= 1'b1;
			end
			if (chg_we) begin
				chg_vld_q[y_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		if (cmd.cur_re) begin
			cur_rd_q <= cur_mem[cur_ra];
			cur_v_q  <= cur_vld_q[cur_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[y_q] <= life;
		end
		if (cmd.nxt_re) begin
			nxt_rd_q <= nxt_mem[cnt_q];
			nxt_v_q  <= nxt_vld_q[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (chg_we) begin
			chg_mem[y_q] <= chg_wd;
		end
		if (cmd.chg_re) begin
			chg_rd_q <= chg_mem[y_q];
			chg_v_q  <= chg_vld_q[y_q];
		end
	end

	logic [DATA_W-1:0] row_bits_q;
	logic [DATA_W-1:0] change_bits_q;

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			unique case (cmd.res_sel)
				RES_LIFE: begin
					row_bits_q    <= DATA_W'(life);
					change_bits_q <= '0;
				end
				RES_FLUSH: begin
					row_bits_q    <= DATA_W'(cur_eff);
					change_bits_q <= DATA_W'(chg_eff);
				end
				default: begin
					row_bits_q    <= '0;
					change_bits_q <= '0;
				end
			endcase
		end
	end

	assign row_bits    = row_bits_q;
	assign change_bits = change_bits_q;

endmodule

// ===== sv/lre_ctrl.sv =====
`timescale 1ns / 1ps

module lre_ctrl import lre_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] op,
	output logic            out_valid,
	input  logic            out_ready,
	input  stat_t           stat,
	output cmd_t            cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_UP,
		S_RD_MID,
		S_RD_DN,
		S_STEP_WB,
		S_SET_RD,
		S_SET_WB,
		S_FLUSH_RD,
		S_FLUSH_WB,
		S_CLR,
		S_CMT,
		S_CMT_END,
		S_ZERO
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   fin;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		cmd.cur_ra  = ADDR_Y;
		cmd.wr      = WR_NONE;
		cmd.res_sel = RES_ZERO;
		state_d   = state_q;
		fin       = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.ld_in   = in_valid;
				cmd.cnt_clr = in_valid;
				if (in_valid) begin
					case (op)
						OP_SET:    state_d = S_SET_RD;
						OP_CLEAR:  state_d = S_CLR;
						OP_STEP:   state_d = S_RD_UP;
						OP_COMMIT: state_d = S_CMT;
						OP_FLUSH:  state_d = S_FLUSH_RD;
						default:   state_d = S_ZERO;
					endcase
				end
			end
			S_RD_UP: begin
				cmd.cur_re = 1'b1;
				cmd.cur_ra = ADDR_UP;
				cmd.chg_re = 1'b1;
				state_d    = S_RD_MID;
			end
			S_RD_MID: begin
				cmd.cur_re = 1'b1;
				cmd.cur_ra = ADDR_Y;
				cmd.cap_up = 1'b1;
				state_d    = S_RD_DN;
			end
			S_RD_DN: begin
				cmd.cur_re  = 1'b1;
				cmd.cur_ra  = ADDR_DN;
				cmd.cap_mid = 1'b1;
				state_d     = S_STEP_WB;
			end
			S_STEP_WB: begin
				cmd.wr      = WR_STEP;
				cmd.res_sel = RES_LIFE;
				fin         = 1'b1;
			end
			S_SET_RD: begin
				cmd.cur_re = 1'b1;
				cmd.chg_re = 1'b1;
				state_d    = S_SET_WB;
			end
			S_SET_WB: begin
				cmd.wr = WR_SET;
				fin    = 1'b1;
			end
			S_FLUSH_RD: begin
				cmd.cur_re = 1'b1;
				cmd.chg_re = 1'b1;
				state_d    = S_FLUSH_WB;
			end
			S_FLUSH_WB: begin
				cmd.wr      = WR_FLUSH;
				cmd.res_sel = RES_FLUSH;
				fin         = 1'b1;
			end
			S_CLR: begin
				cmd.clr_all = 1'b1;
				fin         = 1'b1;
			end
			S_CMT: begin
				cmd.nxt_re = 1'b1;
				cmd.wr     = WR_CMT;
				if (stat.cnt_last) begin
					state_d = S_CMT_END;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_CMT_END: begin
				cmd.wr = WR_CMT_END;
				fin    = 1'b1;
			end
			S_ZERO: begin
				fin = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			cmd.out_ld = slot_free;
			if (slot_free) begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/life_automaton_row_engine_core.sv =====
// Life engine (B3/S23) on a toroidal board of BOARD_ROWS rows by BOARD_COLS columns.
// The input channel (in_valid/in_ready) carries one operation per item: set cell,
// clear, compute next row, commit next board, or flush row. The output channel
// (out_valid/out_ready) returns exactly one item per input item, in order:
// row_bits, zero but for compute and flush row; change_bits, zero but for flush row.
// One item is worked at a time, sequenced over the row memories.
// Set cell and flush row read a row and write it back; compute row makes three
// reads of the current board before its write-back, and commit copies one row
// per cycle from the next board to the current board.
// The next item is accepted in the cycle after its predecessor's result is loaded.
// A result waits in the output register while the receiver stalls; the engine
// accepts the next item meanwhile and holds its finished result until the
// register is free. Reset clears per-row valid bits, so both boards read as
// dead and every cell reads as changed; the engine is ready at once after reset.
`timescale 1ns / 1ps

module life_automaton_row_engine_core import lre_pkg::*; #(
	parameter int BOARD_COLS = 64,
	parameter int BOARD_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [IDX_W-1:0]  col,
	input  logic [IDX_W-1:0]  row,
	input  logic              cell_value,
	input  logic              mark_changed,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] row_bits,
	output logic [DATA_W-1:0] change_bits
);

	cmd_t  cmd;
	stat_t stat;

	lre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lre_datapath #(
		.BOARD_COLS (BOARD_COLS),
		.BOARD_ROWS (BOARD_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.col          (col),
		.row          (row),
		.cell_value   (cell_value),
		.mark_changed (mark_changed),
		.row_bits     (row_bits),
		.change_bits  (change_bits)
	);

endmodule
